### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion helpers shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// assert on the rising edge, off while reset is asserted
`define ASSERT_CLK(lbl, ck, rst_n, prop) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) prop) \
		else $error("assertion failed: lbl");

// assert on the block clock and reset
`define ASSERT_TOP(lbl, prop) \
	`ASSERT_CLK(lbl, clk, arst_n, prop)

`endif

### sv/fsdp_pkg.sv
// ----------------------------------------------------------------------------
// fsdp_pkg
// Constants shared by the decimal printer modules.
// ----------------------------------------------------------------------------
package fsdp_pkg;

	localparam int unsigned VAL_W     = 32;
	localparam int unsigned DIG_MAX   = 10;
	localparam int unsigned DIG_IDX_W = 4;
	localparam int unsigned REC_SHIFT = 35;

	localparam logic [VAL_W-1:0] RECIP_TEN = 32'hCCCC_CCCD;
	localparam logic [VAL_W-1:0] CNT_MAX   = 32'hFFFF_FFFF;

	localparam logic [7:0] CHAR_NUL   = 8'h00;
	localparam logic [7:0] CHAR_PCT   = 8'h25;
	localparam logic [7:0] CHAR_D     = 8'h64;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;
	localparam logic [7:0] ASCII_ZERO = 8'h30;

endpackage

### sv/fsdp_if.sv
// ----------------------------------------------------------------------------
// fsdp channels
// Valid/ready channels for format bytes and printed characters.
// ----------------------------------------------------------------------------
interface fsdp_fmt_if;
	logic               valid;
	logic               ready;
	logic [7:0]         fmt_byte;
	logic signed [31:0] arg_value;

	modport source(output valid, output fmt_byte, output arg_value, input ready);
	modport sink(input valid, input fmt_byte, input arg_value, output ready);
endinterface

interface fsdp_res_if;
	logic        valid;
	logic        ready;
	logic [7:0]  out_char;
	logic        is_char;
	logic        last;
	logic [31:0] total_count;

	modport source(output valid, output out_char, output is_char, output last,
		output total_count, input ready);
	modport sink(input valid, input out_char, input is_char, input last,
		input total_count, output ready);
endinterface

### sv/fsdp_div10.sv
// ----------------------------------------------------------------------------
// fsdp_div10
// Shared divide-by-ten unit: registered reciprocal product, then quotient
// and remainder in the following cycle.
// ----------------------------------------------------------------------------
module fsdp_div10
	import fsdp_pkg::*;
(
	input  logic             clk,
	input  logic             load,
	input  logic [VAL_W-1:0] dividend,
	output logic [VAL_W-1:0] quot,
	output logic [3:0]       rem
);

	logic [2*VAL_W-1:0] prod_s1;
	logic [VAL_W-1:0]   dividend_s1;
	logic [VAL_W-1:0]   back;

	always_ff @(posedge clk) begin
		if (load) begin
			prod_s1     <= {{VAL_W{1'b0}}, dividend} * {{VAL_W{1'b0}}, RECIP_TEN};
			dividend_s1 <= dividend;
		end
	end

	assign quot = {{(REC_SHIFT-VAL_W){1'b0}}, prod_s1[2*VAL_W-1:REC_SHIFT]};
	assign back = dividend_s1 - {quot[VAL_W-4:0], 3'b000} - {quot[VAL_W-2:0], 1'b0};
	assign rem  = back[3:0];

endmodule

### sv/format_string_decimal_printer_top.sv
// ----------------------------------------------------------------------------
// format_string_decimal_printer_top
// Printf-style formatter for plain bytes, %% and %d with a character count.
// ----------------------------------------------------------------------------
// Format bytes are taken one word at a time and only while the sequencer is
// idle. A plain byte, %% or the terminator is accepted, then loaded into the
// output register; a bare % or an unknown conversion is only accepted.
// A %d runs each digit through the shared divide-by-ten unit (registered
// reciprocal product, then remainder), then emits the optional sign and the
// digits, each output waiting while the result channel stalls. A zero byte
// reports the count, then clears it.
`include "assert_macros.svh"

module format_string_decimal_printer_top
	import fsdp_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	fsdp_fmt_if.sink   fmt,
	fsdp_res_if.source res
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ONE,
		ST_MUL,
		ST_REM,
		ST_SIGN,
		ST_DIGS
	} state_t;

	state_t               state_q;
	logic                 pend_q;
	logic [VAL_W-1:0]     cnt_q;
	logic [VAL_W-1:0]     cnt_inc;
	logic [VAL_W-1:0]     mag_q;
	logic [VAL_W-1:0]     arg_mag;
	logic                 neg_q;
	logic [3:0]           dig_q [DIG_MAX];
	logic [DIG_IDX_W-1:0] ndig_q;
	logic [DIG_IDX_W-1:0] idx_q;
	logic [7:0]           ch_q;
	logic                 is_ch_q;

	logic                 out_valid_q;
	logic [7:0]           out_char_q;
	logic                 out_is_char_q;
	logic                 out_last_q;
	logic [VAL_W-1:0]     out_total_q;

	logic                 slot_free;
	logic                 out_load;
	logic                 accept;
	logic                 div_load;
	logic [VAL_W-1:0]     div_quot;
	logic [3:0]           div_rem;

	assign slot_free = !out_valid_q || res.ready;
	assign out_load  = slot_free && (state_q inside {ST_ONE, ST_SIGN, ST_DIGS});
	assign accept    = fmt.valid && fmt.ready;
	assign cnt_inc   = (cnt_q == CNT_MAX) ? cnt_q : cnt_q + 1'b1;
	assign arg_mag   = fmt.arg_value[VAL_W-1] ? (~fmt.arg_value) + 1'b1 : fmt.arg_value;
	assign div_load  = (state_q == ST_MUL);

	fsdp_div10 u_div10 (
		.clk      (clk),
		.load     (div_load),
		.dividend (mag_q),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pend_q      <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			ndig_q      <= '0;
			idx_q       <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (fmt.fmt_byte == CHAR_NUL) begin
							pend_q  <= 1'b0;
							ch_q    <= CHAR_NUL;
							is_ch_q <= 1'b0;
							state_q <= ST_ONE;
						end else if (pend_q) begin
							pend_q <= 1'b0;
							if (fmt.fmt_byte == CHAR_PCT) begin
								ch_q    <= CHAR_PCT;
								is_ch_q <= 1'b1;
								state_q <= ST_ONE;
							end else if (fmt.fmt_byte == CHAR_D) begin
								mag_q   <= arg_mag;
								neg_q   <= fmt.arg_value[VAL_W-1];
								ndig_q  <= '0;
								state_q <= ST_MUL;
							end
						end else if (fmt.fmt_byte == CHAR_PCT) begin
							pend_q <= 1'b1;
						end else begin
							ch_q    <= fmt.fmt_byte;
							is_ch_q <= 1'b1;
							state_q <= ST_ONE;
						end
					end
				end
				ST_ONE: begin
					if (slot_free) begin
						out_char_q    <= ch_q;
						out_is_char_q <= is_ch_q;
						out_last_q    <= 1'b1;
						if (is_ch_q) begin
							cnt_q       <= cnt_inc;
							out_total_q <= cnt_inc;
						end else begin
							cnt_q       <= '0;
							out_total_q <= cnt_q;
						end
						state_q <= ST_IDLE;
					end
				end
				ST_MUL: begin
					state_q <= ST_REM;
				end
				ST_REM: begin
					dig_q[ndig_q] <= div_rem;
					ndig_q        <= ndig_q + 1'b1;
					mag_q         <= div_quot;
					if (div_quot == '0) begin
						idx_q   <= ndig_q;
						state_q <= neg_q ? ST_SIGN : ST_DIGS;
					end else begin
						state_q <= ST_MUL;
					end
				end
				ST_SIGN: begin
					if (slot_free) begin
						out_char_q    <= CHAR_MINUS;
						out_is_char_q <= 1'b1;
						out_last_q    <= 1'b0;
						cnt_q         <= cnt_inc;
						out_total_q   <= cnt_inc;
						state_q       <= ST_DIGS;
					end
				end
				ST_DIGS: begin
					if (slot_free) begin
						out_char_q    <= ASCII_ZERO + {4'b0000, dig_q[idx_q]};
						out_is_char_q <= 1'b1;
						out_last_q    <= (idx_q == '0);
						cnt_q         <= cnt_inc;
						out_total_q   <= cnt_inc;
						if (idx_q == '0) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q <= idx_q - 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign fmt.ready       = (state_q == ST_IDLE);
	assign res.valid       = out_valid_q;
	assign res.out_char    = out_char_q;
	assign res.is_char     = out_is_char_q;
	assign res.last        = out_last_q;
	assign res.total_count = out_total_q;

	`ASSERT_TOP(a_ndig_range, ndig_q <= DIG_IDX_W'(DIG_MAX))
	`ASSERT_TOP(a_idx_in_digits, (state_q == ST_DIGS) |-> (idx_q < ndig_q))
	`ASSERT_TOP(a_report_clears, (state_q == ST_ONE && slot_free && !is_ch_q) |=> (cnt_q == '0))
	`ASSERT_TOP(a_report_form, (res.valid && !res.is_char) |-> (res.last && res.out_char == CHAR_NUL))

endmodule
